[sv/bgc_pkg.sv]
// Shared types, constants and helpers for the button gesture classifier.
package bgc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_val_t;

  localparam count_t CountMax = {CountWidth{1'b1}};

  localparam logic [ApbAddrW-1:0] AddrHoldTicks = ApbAddrW'(0);
  localparam logic [ApbAddrW-1:0] AddrWindow    = ApbAddrW'(4);

  localparam cfg_val_t HoldTicksRst = CfgWidth'(50);
  localparam cfg_val_t WindowRst    = CfgWidth'(20);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HELD   = 2'd3
  } event_e;

  typedef struct packed {
    op_e  op;
    logic pin_level;
  } item_t;

  typedef struct packed {
    cfg_val_t hold_ticks;
    cfg_val_t double_click_window;
  } cfg_t;

  function automatic count_t sat_to_count(input cfg_val_t v);
    logic [32:0] wide_v;
    logic [32:0] wide_max;
    wide_v   = 33'(v);
    wide_max = (33'd1 << CountWidth) - 33'd1;
    if (wide_v > wide_max) begin
      return count_t'(wide_max);
    end
    return count_t'(wide_v);
  endfunction

endpackage

[sv/bgc_regs.sv]
// APB configuration registers for the button gesture classifier.
module bgc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bgc_pkg::ApbDataW-1:0]  pwdata,
  output logic [bgc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output bgc_pkg::cfg_t                 cfg_o
);
  import bgc_pkg::*;

  cfg_val_t hold_q, hold_d;
  cfg_val_t window_q, window_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    hold_d   = hold_q;
    window_d = window_q;
    if (wr_en) begin
      unique case (paddr)
        AddrHoldTicks: hold_d   = pwdata[CfgWidth-1:0];
        AddrWindow:    window_d = pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrHoldTicks: prdata = ApbDataW'(hold_q);
      AddrWindow:    prdata = ApbDataW'(window_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= HoldTicksRst;
      window_q <= WindowRst;
    end else begin
      hold_q   <= hold_d;
      window_q <= window_d;
    end
  end

  assign cfg_o.hold_ticks          = hold_q;
  assign cfg_o.double_click_window = window_q;

endmodule

[sv/bgc_in_stage.sv]
// Input register stage holding one accepted item.
module bgc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bgc_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bgc_pkg::item_t item_o
);
  import bgc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/bgc_core.sv]
// Gesture state: press and window counters, event latch and classification.
module bgc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bgc_pkg::item_t    item_i,
  input  bgc_pkg::cfg_t     cfg_i,
  output bgc_pkg::event_e   event_o
);
  import bgc_pkg::*;

  count_t press_q, press_d;
  count_t window_q, window_d;
  event_e latch_q, latch_d;
  event_e raised;
  count_t hold;
  count_t full;

  assign hold = sat_to_count(cfg_i.hold_ticks);
  assign full = sat_to_count(cfg_i.double_click_window);

  always_comb begin
    press_d  = press_q;
    window_d = window_q;
    latch_d  = latch_q;
    raised   = EV_NONE;
    event_o  = EV_NONE;
    if (item_i.op == OP_READ) begin
      event_o = latch_q;
      latch_d = EV_NONE;
    end else begin
      if (!item_i.pin_level) begin
        if (press_q != CountMax) begin
          press_d = press_q + count_t'(1);
        end
      end else if (press_q != '0) begin
        if (press_q >= hold) begin
          raised   = EV_HELD;
          window_d = '0;
        end else if (window_q != '0) begin
          if (window_q < full) begin
            raised   = EV_DOUBLE;
            window_d = '0;
          end
        end else begin
          window_d = full;
        end
        press_d = '0;
      end else if (window_q != '0) begin
        window_d = window_q - count_t'(1);
        if (window_q == count_t'(1)) begin
          raised = EV_CLICK;
        end
      end
      if (raised != EV_NONE) begin
        latch_d = raised;
      end
      event_o = raised;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q  <= '0;
      window_q <= '0;
      latch_q  <= EV_NONE;
    end else if (fire_i) begin
      press_q  <= press_d;
      window_q <= window_d;
      latch_q  <= latch_d;
    end
  end

endmodule

[sv/bgc_out_stage.sv]
// Result register stage holding one finished item.
module bgc_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bgc_pkg::event_e event_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bgc_pkg::event_e event_o
);
  import bgc_pkg::*;

  logic   valid_q, valid_d;
  event_e event_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      event_q <= event_i;
    end
  end

  assign valid_o = valid_q;
  assign event_o = event_q;

endmodule

[sv/button_gesture_classifier.sv]
// Button gesture classifier top level: click, double click and hold events.
// Input stream: s_axis_tuser carries the opcode (0 poll tick, 1 read and
// clear the latched event), s_axis_tdata[0] the raw pin level (0 pressed).
// Each input item yields exactly one result item on the output stream,
// m_axis_tdata[1:0] = event (0 none, 1 click, 2 double click, 3 held).
// A tick reports the event it raised; a read reports and clears the latch.
// Path: input register, then result register. Throughput: one item per
// cycle while the receiver does not stall, set by the single pass of
// counter compares between the two registers.
// When the receiver stalls, the result register holds its item and the
// input register holds the next one; counters and latch change only when an
// item moves into the result register, so nothing is lost or repeated.
// Reset clears both counters, the latch and both stages, and loads
// hold_ticks = 50 and double_click_window = 20.
// Configuration: APB, hold_ticks at 0x0, double_click_window at 0x4, bits
// [15:0]; write only while no item is in flight.
module button_gesture_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] pin_level, [7:1] zero
  input  logic                          s_axis_tuser,  // [0] opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [1:0] event_res, [7:2] zero
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bgc_pkg::ApbDataW-1:0]  pwdata,
  output logic [bgc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bgc_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  item_t  stage_item;
  logic   stage_valid;
  logic   out_ready;
  event_e core_event;
  event_e out_event;

  assign in_item.op        = op_e'(s_axis_tuser);
  assign in_item.pin_level = s_axis_tdata[0];

  bgc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (out_ready),
    .item_o  (stage_item)
  );

  bgc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (stage_valid && out_ready),
    .item_i  (stage_item),
    .cfg_i   (cfg),
    .event_o (core_event)
  );

  bgc_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (out_ready),
    .event_i (core_event),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .event_o (out_event)
  );

  assign m_axis_tdata = {6'd0, out_event};

endmodule
